FILE: src/gcknn_pkg.sv
package gcknn_pkg;

  // One input word and one result word.
  typedef struct packed {
    logic               mode;
    logic signed [15:0] sample_value;
    logic [9:0]         node_row;
    logic [3:0]         neighbor_slot;
    logic [9:0]         neighbor_node;
    logic [16:0]        edge_weight;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic [31:0] geary_value;
    logic [1:0]  status;
  } out_word_t;

  // Accumulator and arithmetic widths, sized for the largest graph.
  localparam int NUM_W  = 56;
  localparam int WTOT_W = 32;
  localparam int VSUM_W = 27;
  localparam int DEV_W  = 48;
  localparam int SQ_W   = 47;
  localparam int NQ_W   = 63;
  localparam int S2_W   = 54;
  localparam int MA_W   = 56;
  localparam int MB_W   = 33;
  localparam int MP_W   = 89;
  localparam int DR_W   = 82;
  localparam int DQ_W   = 64;
  localparam int STEP_W = 7;

  localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(MB_W);
  localparam logic [STEP_W-1:0] VAR_STEPS = STEP_W'(DQ_W);
  localparam logic [STEP_W-1:0] GQ_STEPS  = STEP_W'(32);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic MODE_GRAPH  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {RES_OK, RES_SAT, RES_DEGEN, RES_BAD} res_kind_t;
  typedef enum logic [2:0] {AR_NQ, AR_VAR, AR_P1, AR_P2, AR_GQ} arith_sel_t;
  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_WALK_WAIT, S_NQ_GO, S_NQ_WAIT, S_VAR_GO, S_VAR_WAIT,
    S_CHECK, S_P1_GO, S_P1_WAIT, S_P2_GO, S_P2_WAIT, S_SAT_CHECK, S_GQ_GO,
    S_GQ_WAIT, S_FINISH
  } state_t;

  typedef struct packed {
    logic       take;
    logic       walk_start;
    logic       arith_start;
    logic       arith_latch;
    arith_sel_t arith_sel;
    logic       out_load;
    res_kind_t  kind;
    logic       clear_vector;
  } cmd_t;

  typedef struct packed {
    logic n_lt2;
    logic walk_busy;
    logic arith_busy;
    logic bad;
    logic degen;
    logic sat;
    logic out_full;
  } stat_t;

endpackage

FILE: src/gcknn_arith.sv
module gcknn_arith (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  gcknn_pkg::arith_op_t          op,
  input  logic [gcknn_pkg::MA_W-1:0]    mul_a,
  input  logic [gcknn_pkg::MB_W-1:0]    mul_b,
  input  logic [gcknn_pkg::DR_W-1:0]    div_rem0,
  input  logic [gcknn_pkg::DQ_W-1:0]    div_num0,
  input  logic [gcknn_pkg::DR_W-1:0]    div_den,
  input  logic [gcknn_pkg::STEP_W-1:0]  steps,
  output logic                          busy,
  output logic [gcknn_pkg::MP_W-1:0]    product,
  output logic [gcknn_pkg::DQ_W-1:0]    quotient
);
  import gcknn_pkg::*;

  logic [STEP_W-1:0] count;
  arith_op_t         op_r;
  logic [MP_W-1:0]   acc;
  logic [MP_W-1:0]   mcand;
  logic [MB_W-1:0]   mplier;
  logic [DR_W-1:0]   rem;
  logic [DQ_W-1:0]   quo;
  logic [DR_W-1:0]   den;
  logic [DR_W:0]     rem_sh;
  logic [DR_W:0]     rem_sub;
  logic              rem_ge;

  // Restoring division step: bring in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem, quo[DQ_W-1]};
    rem_ge  = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  // Sequencing: one step per cycle until the step count runs out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      op_r  <= OP_MUL;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
      op_r  <= op;
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift-add multiplier and restoring divider share the step counter.
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= MP_W'(mul_a);
      mplier <= mul_b;
      rem    <= div_rem0;
      quo    <= div_num0;
      den    <= div_den;
    end else if (busy) begin
      unique case (op_r)
        OP_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[MP_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[MB_W-1:1]};
        end
        OP_DIV: begin
          if (rem_ge) begin
            rem <= rem_sub[DR_W-1:0];
            quo <= {quo[DQ_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DR_W-1:0];
            quo <= {quo[DQ_W-2:0], 1'b0};
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign product  = acc;
  assign quotient = quo;

endmodule

FILE: src/gcknn_dp.sv
module gcknn_dp #(
  parameter int MAX_NODES      = 1024,
  parameter int NEIGHBOR_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gcknn_pkg::in_word_t  in_word,
  input  gcknn_pkg::cmd_t      cmd,
  output gcknn_pkg::stat_t     stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gcknn_pkg::out_word_t out_word
);
  import gcknn_pkg::*;

  localparam int NW     = $clog2(MAX_NODES);
  localparam int SW     = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam int GDEPTH = MAX_NODES * NEIGHBOR_SLOTS;
  localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int CW     = $clog2(MAX_NODES + 1);

  localparam logic signed [VSUM_W-1:0] VSUM_MAX = {1'b0, {(VSUM_W-1){1'b1}}};
  localparam logic signed [VSUM_W-1:0] VSUM_MIN = {1'b1, {(VSUM_W-1){1'b0}}};
  localparam logic [DEV_W-1:0]         DEV_MAX  = '1;

  // Stores.
  logic signed [15:0] smem [MAX_NODES];
  logic [26:0]        gmem [GDEPTH];

  // Vector state.
  logic [CW-1:0]             count;
  logic signed [VSUM_W-1:0]  vsum;
  logic [SQ_W-1:0]           sqsum;
  logic [S2_W-1:0]           s2;

  // Walk state.
  logic                      issuing;
  logic [GAW-1:0]            e;
  logic [NW-1:0]             i;
  logic [SW-1:0]             s;
  logic [NW-1:0]             i1;
  logic                      v1, v2, v3, v4;
  logic [26:0]               g_q;
  logic signed [15:0]        xa_q, xb_q;
  logic [16:0]               w2, w3, w4;
  logic                      bad2, bad3, bad4;
  logic [31:0]               dsq3;
  logic [32:0]               term4;
  logic [NUM_W-1:0]          num;
  logic [WTOT_W-1:0]         wtot;
  logic                      bad;

  // Final arithmetic results.
  logic [NQ_W-1:0]           nq;
  logic [DEV_W-1:0]          dev;
  logic [DR_W-1:0]           p1;
  logic [DR_W-1:0]           dd;
  logic [31:0]               qv;

  // Combinational helpers.
  logic [31:0]               g_full;
  logic                      g_we;
  logic                      s_we;
  logic [15:0]               ax;
  logic [31:0]               ax2;
  logic signed [VSUM_W:0]    vs_ext;
  logic [9:0]                g_nb;
  logic [16:0]               g_w;
  logic signed [16:0]        d;
  logic [15:0]               ad;
  logic [48:0]               prod;
  logic [NUM_W:0]            num_sum;
  logic [WTOT_W:0]           wtot_sum;
  logic [VSUM_W-1:0]         mag;
  logic                      walk_last;

  arith_op_t                 a_op;
  logic [MA_W-1:0]           a_mul_a;
  logic [MB_W-1:0]           a_mul_b;
  logic [DR_W-1:0]           a_rem0;
  logic [DQ_W-1:0]           a_num0;
  logic [DR_W-1:0]           a_den;
  logic [STEP_W-1:0]         a_steps;
  logic                      a_busy;
  logic [MP_W-1:0]           a_prod;
  logic [DQ_W-1:0]           a_quo;

  // Input decode for graph writes and sample loads.
  always_comb begin
    g_full = 32'(in_word.node_row) * 32'(NEIGHBOR_SLOTS) + 32'(in_word.neighbor_slot);
    g_we   = cmd.take && (in_word.mode == MODE_GRAPH) &&
             (32'(in_word.node_row) < 32'(MAX_NODES)) &&
             (32'(in_word.neighbor_slot) < 32'(NEIGHBOR_SLOTS));
    s_we   = cmd.take && (in_word.mode == MODE_SAMPLE) && (32'(count) < 32'(MAX_NODES));
    ax     = in_word.sample_value[15] ? 16'(-in_word.sample_value) : in_word.sample_value;
    ax2    = ax * ax;
    vs_ext = {vsum[VSUM_W-1], vsum} +
             {{(VSUM_W-15){in_word.sample_value[15]}}, in_word.sample_value};
    mag    = vsum[VSUM_W-1] ? VSUM_W'(-vsum) : vsum;
  end

  // Sample store: one write port, two registered read ports for the walk.
  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[count[NW-1:0]] <= in_word.sample_value;
    end
    xa_q <= smem[i1];
    xb_q <= smem[NW'(g_q[26:17])];
  end

  // Graph store: neighbour index and weight packed per slot.
  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_full[GAW-1:0]] <= {in_word.neighbor_node, in_word.edge_weight};
    end
    g_q <= gmem[e];
  end

  // Running count, value sum and sum of squares of the current vector.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_vector) begin
      count <= '0;
      vsum  <= '0;
      sqsum <= '0;
    end else if (s_we) begin
      count <= count + 1'b1;
      sqsum <= sqsum + SQ_W'(ax2);
      if (vs_ext[VSUM_W] != vs_ext[VSUM_W-1]) begin
        vsum <= vs_ext[VSUM_W] ? VSUM_MIN : VSUM_MAX;
      end else begin
        vsum <= vs_ext[VSUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2 <= mag * mag;
  end

  // Edge walk issue: one graph slot per cycle across rows 0 to N-1.
  assign walk_last = (32'(i) + 32'd1 == 32'(count)) &&
                     (32'(s) == 32'(NEIGHBOR_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        issuing <= 1'b1;
      end else if (issuing && walk_last) begin
        issuing <= 1'b0;
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      e <= '0;
      i <= '0;
      s <= '0;
    end else if (issuing) begin
      e <= e + 1'b1;
      if (32'(s) == 32'(NEIGHBOR_SLOTS - 1)) begin
        s <= '0;
        i <= i + 1'b1;
      end else begin
        s <= s + 1'b1;
      end
    end
    i1 <= i;
  end

  // Edge pipeline: difference, square, weighting.
  always_comb begin
    g_nb = g_q[26:17];
    g_w  = g_q[16:0];
    d    = {xa_q[15], xa_q} - {xb_q[15], xb_q};
    ad   = d[16] ? 16'(-d) : d[15:0];
    prod = dsq3 * w3;
  end

  always_ff @(posedge clk) begin
    w2    <= g_w;
    bad2  <= 32'(g_nb) >= 32'(count);
    dsq3  <= ad * ad;
    w3    <= w2;
    bad3  <= bad2;
    term4 <= prod[48:16];
    w4    <= w3;
    bad4  <= bad3;
  end

  // Saturating sums of weighted squared differences and weights.
  always_comb begin
    num_sum  = {1'b0, num} + (NUM_W+1)'(term4);
    wtot_sum = {1'b0, wtot} + (WTOT_W+1)'(w4);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.walk_start) begin
      num  <= '0;
      wtot <= '0;
      bad  <= 1'b0;
    end else if (v4) begin
      if (bad4) begin
        bad <= 1'b1;
      end else begin
        num  <= num_sum[NUM_W] ? {NUM_W{1'b1}} : num_sum[NUM_W-1:0];
        wtot <= wtot_sum[WTOT_W] ? {WTOT_W{1'b1}} : wtot_sum[WTOT_W-1:0];
      end
    end
  end

  // Operand selection for the shared multiply and divide unit.
  always_comb begin
    a_op    = OP_MUL;
    a_mul_a = '0;
    a_mul_b = '0;
    a_rem0  = '0;
    a_num0  = '0;
    a_den   = '0;
    a_steps = MUL_STEPS;
    unique case (cmd.arith_sel)
      AR_NQ: begin
        a_mul_a = MA_W'(sqsum);
        a_mul_b = MB_W'(count);
      end
      AR_VAR: begin
        a_op    = OP_DIV;
        a_num0  = (nq >= NQ_W'(s2)) ? DQ_W'(nq - NQ_W'(s2)) : '0;
        a_den   = DR_W'(count);
        a_steps = VAR_STEPS;
      end
      AR_P1: begin
        a_mul_a = num;
        a_mul_b = MB_W'(count - 1'b1);
      end
      AR_P2: begin
        a_mul_a = MA_W'(dev);
        a_mul_b = {wtot, 1'b0};
      end
      AR_GQ: begin
        a_op    = OP_DIV;
        a_rem0  = p1;
        a_den   = dd;
        a_steps = GQ_STEPS;
      end
      default: begin
        a_op = OP_MUL;
      end
    endcase
  end

  gcknn_arith u_arith (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.arith_start),
    .op       (a_op),
    .mul_a    (a_mul_a),
    .mul_b    (a_mul_b),
    .div_rem0 (a_rem0),
    .div_num0 (a_num0),
    .div_den  (a_den),
    .steps    (a_steps),
    .busy     (a_busy),
    .product  (a_prod),
    .quotient (a_quo)
  );

  // Capture each finished result.
  always_ff @(posedge clk) begin
    if (cmd.arith_latch) begin
      unique case (cmd.arith_sel)
        AR_NQ:  nq  <= a_prod[NQ_W-1:0];
        AR_VAR: dev <= (a_quo > DQ_W'(DEV_MAX)) ? DEV_MAX : a_quo[DEV_W-1:0];
        AR_P1:  p1  <= a_prod[DR_W-1:0];
        AR_P2:  dd  <= a_prod[DR_W-1:0];
        AR_GQ:  qv  <= a_quo[31:0];
        default: qv <= qv;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.kind)
        RES_OK:    out_word <= '{geary_value: qv,     status: ST_OK};
        RES_SAT:   out_word <= '{geary_value: '1,     status: ST_OK};
        RES_DEGEN: out_word <= '{geary_value: '0,     status: ST_DEGEN};
        RES_BAD:   out_word <= '{geary_value: '0,     status: ST_BAD};
        default:   out_word <= '{geary_value: '0,     status: ST_DEGEN};
      endcase
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.n_lt2      = count < CW'(2);
    stat.walk_busy  = issuing || v1 || v2 || v3 || v4;
    stat.arith_busy = a_busy;
    stat.bad        = bad;
    stat.degen      = (wtot == '0) || (dev == '0);
    stat.sat        = p1 >= dd;
    stat.out_full   = out_valid;
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a word not yet taken");

  a_arith_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.arith_start |-> !a_busy)
    else $error("arithmetic unit restarted while busy");

  a_take_quiet: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (!stat.walk_busy && !a_busy))
    else $error("input word taken during computation");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_NODES))
    else $error("sample count beyond store depth");

endmodule

FILE: src/gcknn_ctrl.sv
module gcknn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_mode,
  input  logic              in_last,
  input  logic              out_ready,
  input  gcknn_pkg::stat_t  stat,
  output logic              in_ready,
  output gcknn_pkg::cmd_t   cmd
);
  import gcknn_pkg::*;

  state_t    state, state_next;
  res_kind_t kind, kind_next;

  // State and result kind registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= RES_OK;
    end else begin
      state <= state_next;
      kind  <= kind_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    kind_next  = kind;
    in_ready   = 1'b0;
    cmd        = '{take: 1'b0, walk_start: 1'b0, arith_start: 1'b0, arith_latch: 1'b0,
                   arith_sel: AR_NQ, out_load: 1'b0, kind: kind, clear_vector: 1'b0};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode == MODE_SAMPLE && in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (stat.n_lt2) begin
          kind_next  = RES_DEGEN;
          state_next = S_FINISH;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        if (!stat.walk_busy) begin
          state_next = S_NQ_GO;
        end
      end
      S_NQ_GO: begin
        cmd.arith_start = 1'b1;
        state_next      = S_NQ_WAIT;
      end
      S_NQ_WAIT: begin
        if (!stat.arith_busy) begin
          cmd.arith_latch = 1'b1;
          state_next      = S_VAR_GO;
        end
      end
      S_VAR_GO: begin
        cmd.arith_sel   = AR_VAR;
        cmd.arith_start = 1'b1;
        state_next      = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        cmd.arith_sel = AR_VAR;
        if (!stat.arith_busy) begin
          cmd.arith_latch = 1'b1;
          state_next      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.bad) begin
          kind_next  = RES_BAD;
          state_next = S_FINISH;
        end else if (stat.degen) begin
          kind_next  = RES_DEGEN;
          state_next = S_FINISH;
        end else begin
          state_next = S_P1_GO;
        end
      end
      S_P1_GO: begin
        cmd.arith_sel   = AR_P1;
        cmd.arith_start = 1'b1;
        state_next      = S_P1_WAIT;
      end
      S_P1_WAIT: begin
        cmd.arith_sel = AR_P1;
        if (!stat.arith_busy) begin
          cmd.arith_latch = 1'b1;
          state_next      = S_P2_GO;
        end
      end
      S_P2_GO: begin
        cmd.arith_sel   = AR_P2;
        cmd.arith_start = 1'b1;
        state_next      = S_P2_WAIT;
      end
      S_P2_WAIT: begin
        cmd.arith_sel = AR_P2;
        if (!stat.arith_busy) begin
          cmd.arith_latch = 1'b1;
          state_next      = S_SAT_CHECK;
        end
      end
      S_SAT_CHECK: begin
        if (stat.sat) begin
          kind_next  = RES_SAT;
          state_next = S_FINISH;
        end else begin
          state_next = S_GQ_GO;
        end
      end
      S_GQ_GO: begin
        cmd.arith_sel   = AR_GQ;
        cmd.arith_start = 1'b1;
        state_next      = S_GQ_WAIT;
      end
      S_GQ_WAIT: begin
        cmd.arith_sel = AR_GQ;
        if (!stat.arith_busy) begin
          cmd.arith_latch = 1'b1;
          kind_next       = RES_OK;
          state_next      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_full || out_ready) begin
          cmd.out_load     = 1'b1;
          cmd.clear_vector = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/geary_c_knn_graph_unit.sv
// Geary's C over a stored k-nearest-neighbour graph. Graph-entry words and sample words are
// taken while the unit is idle. The sample word that carries the last-sample mark starts the
// computation, during which no input word is taken: the edge walk reads one graph slot per
// cycle through the graph memory and then drains its pipeline, and then one serial
// multiply/divide unit works out the variance and the quotient in three multiplies and two
// divisions. A degenerate, bad or saturated result skips the remaining steps. The result waits
// in an output register, so loading of the next vector may start before it is taken. No
// clearing pass follows reset.
module geary_c_knn_graph_unit #(
  parameter int MAX_NODES      = 1024,
  parameter int NEIGHBOR_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gcknn_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gcknn_pkg::out_word_t out_word
);
  import gcknn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gcknn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_word.mode),
    .in_last   (in_word.last_sample),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  gcknn_dp #(
    .MAX_NODES      (MAX_NODES),
    .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: test/tb_geary_c_knn_graph_unit.sv
module tb_geary_c_knn_graph_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gcknn_pkg::*;

  localparam int NODES      = 1024;
  localparam int SLOTS      = 16;
  localparam int EDGES      = NODES * SLOTS;
  localparam int IDLE_LIMIT = 100000;
  localparam int HOLD_LEN   = 2500;
  localparam int TAIL_WAIT  = 400;
  localparam longint unsigned NUM_CAP  = (64'd1 << 56) - 1;
  localparam longint unsigned DEV_CAP  = (64'd1 << 48) - 1;
  localparam longint unsigned WTOT_CAP = 64'hFFFF_FFFF;
  localparam longint VSUM_HI = 67108863;
  localparam longint VSUM_LO = -67108864;

  typedef struct {
    in_word_t word;
    bit       drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  pending_t  word_queue[$];
  out_word_t geary_due[$];
  int        error_count = 0;
  int        issue_cnt = 0;
  int        accept_cnt = 0;
  int        result_cnt = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_left = 0;
  bit        held_once = 1'b0;
  int        idle_cycles = 0;

  // Shadow of the block's contents, updated as each word is accepted.
  logic signed [15:0] node_value[NODES];
  logic [9:0]         edge_nbr[EDGES];
  logic [16:0]        edge_wt[EDGES];
  int                 value_count = 0;
  longint             value_total = 0;

  // Generation-side view of the graph, so that no unwritten slot is walked.
  int gen_nbr[EDGES];
  bit gen_written[EDGES];

  geary_c_knn_graph_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Geary's C for the vector held in the shadow.
  function automatic out_word_t geary_result();
    out_word_t       r;
    longint unsigned num, wtot, sq, s2, nq, dev, mag, ad, term;
    logic [127:0]    numer, denom;
    bit              bad;
    int              n, idx, nb, d;
    r.geary_value = '0;
    r.status = ST_DEGEN;
    n = value_count;
    if (n < 2) return r;
    num = 0;
    wtot = 0;
    sq = 0;
    bad = 1'b0;
    for (int i = 0; i < n; i++) begin
      for (int s = 0; s < SLOTS; s++) begin
        idx = i * SLOTS + s;
        nb = int'(edge_nbr[idx]);
        if (nb >= n) begin
          bad = 1'b1;
          continue;
        end
        d = int'(node_value[i]) - int'(node_value[nb]);
        ad = (d < 0) ? -d : d;
        term = (ad * ad * longint'(edge_wt[idx])) >> 16;
        num = (NUM_CAP - num < term) ? NUM_CAP : num + term;
        wtot = wtot + longint'(edge_wt[idx]);
        if (wtot > WTOT_CAP) wtot = WTOT_CAP;
      end
    end
    for (int i = 0; i < n; i++) begin
      d = int'(node_value[i]);
      ad = (d < 0) ? -d : d;
      sq += ad * ad;
    end
    mag = (value_total < 0) ? -value_total : value_total;
    s2 = mag * mag;
    nq = longint'(n) * sq;
    dev = (s2 > nq) ? 0 : (nq - s2) / n;
    if (dev > DEV_CAP) dev = DEV_CAP;
    if (bad) begin
      r.status = ST_BAD;
      return r;
    end
    if (wtot == 0 || dev == 0) return r;
    r.status = ST_OK;
    numer = (128'(n - 1) * 128'(num)) << 32;
    denom = 128'(2 * wtot) * 128'(dev);
    if (numer >= (denom << 32)) r.geary_value = 32'hFFFF_FFFF;
    else r.geary_value = 32'(numer / denom);
    return r;
  endfunction

  // Apply one accepted word to the shadow and queue any result it causes.
  task automatic absorb_word(input in_word_t w);
    int idx;
    if (w.mode == MODE_GRAPH) begin
      idx = {w.node_row, w.neighbor_slot};
      edge_nbr[idx] = w.neighbor_node;
      edge_wt[idx] = w.edge_weight;
    end else begin
      if (value_count < NODES) begin
        node_value[value_count] = w.sample_value;
        value_count++;
        value_total += longint'(w.sample_value);
        if (value_total > VSUM_HI) value_total = VSUM_HI;
        if (value_total < VSUM_LO) value_total = VSUM_LO;
      end
      if (w.last_sample) begin
        geary_due.push_back(geary_result());
        value_count = 0;
        value_total = 0;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic put_graph(input int row, input int slot, input int nb,
                           input logic [16:0] wt, input bit mark);
    pending_t p;
    p.drain = 1'b0;
    p.word.mode = MODE_GRAPH;
    p.word.sample_value = 16'($urandom);
    p.word.node_row = 10'(row);
    p.word.neighbor_slot = 4'(slot);
    p.word.neighbor_node = 10'(nb);
    p.word.edge_weight = wt;
    p.word.last_sample = mark;
    word_queue.push_back(p);
    gen_nbr[row * SLOTS + slot] = nb;
    gen_written[row * SLOTS + slot] = 1'b1;
  endtask

  task automatic put_sample(input logic [15:0] v, input bit mark);
    pending_t p;
    p.drain = 1'b0;
    p.word.mode = MODE_SAMPLE;
    p.word.sample_value = v;
    p.word.node_row = 10'($urandom);
    p.word.neighbor_slot = 4'($urandom);
    p.word.neighbor_node = 10'($urandom);
    p.word.edge_weight = 17'($urandom);
    p.word.last_sample = mark;
    word_queue.push_back(p);
  endtask

  task automatic put_drain();
    pending_t p;
    p.drain = 1'b1;
    p.word = '0;
    word_queue.push_back(p);
  endtask

  // One sample vector of n nodes. Flavours: 0 normal, 1 constant values,
  // 2 zero weights, 3 neighbour beyond the samples, 4 extreme values.
  task automatic put_vector(input int n, input int flavour);
    int idx, row;
    logic [15:0] v;
    v = pick_value();
    for (int r = 0; r < n && r < NODES; r++) begin
      for (int s = 0; s < SLOTS; s++) begin
        idx = r * SLOTS + s;
        if (flavour == 2)
          put_graph(r, s, $urandom_range(n - 1), 17'd0, 1'b0);
        else if (!gen_written[idx] || gen_nbr[idx] >= n || $urandom_range(9) == 0)
          put_graph(r, s, $urandom_range(n - 1), pick_weight(), 1'b0);
      end
    end
    if (flavour == 3) begin
      row = $urandom_range(n - 1);
      put_graph(row, $urandom_range(SLOTS - 1), $urandom_range(n, NODES - 1),
                pick_weight(), 1'b0);
    end
    for (int i = 0; i < n; i++) begin
      // Graph words for rows outside the vector may arrive between samples.
      if (flavour == 0 && n < 64 && $urandom_range(7) == 0)
        put_graph($urandom_range(64, NODES - 1), $urandom_range(SLOTS - 1),
                  $urandom_range(NODES - 1), pick_weight(), 1'($urandom_range(1)));
      if (flavour == 4) v = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
      else if (flavour != 1) v = pick_value();
      put_sample(v, i == n - 1);
    end
  endtask

  // Driver: words change at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && accept_cnt != issue_cnt)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (word_queue[0].drain) begin
        if (geary_due.size() == 0) void'(word_queue.pop_front());
        in_valid <= 1'b0;
      end else begin
        in_word <= word_queue[0].word;
        void'(word_queue.pop_front());
        in_valid <= 1'b1;
        issue_cnt++;
        send_gap = (issue_cnt % 200 < 40) ? 0 : pick_gap();
      end
    end
  end

  // Receiver: random stalls and one long hold-off while words keep coming.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!held_once && issue_cnt >= 300) begin
      held_once = 1'b1;
      hold_left = HOLD_LEN;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap = (result_cnt % 40 < 8) ? 0 : pick_gap();
    end
  end

  // Monitor: accepted words feed the shadow; results are checked in order.
  always @(posedge clk) begin
    out_word_t due;
    if (!rst && in_valid && in_ready) begin
      absorb_word(in_word);
      accept_cnt++;
    end
    if (!rst && out_valid && out_ready) begin
      result_cnt++;
      if (geary_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0h status %0d",
                                  out_word.geary_value, out_word.status));
      end else begin
        due = geary_due.pop_front();
        if (out_word.status !== due.status)
          report_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                    result_cnt, out_word.status, due.status));
        if (out_word.geary_value !== due.geary_value)
          report_mismatch($sformatf("result %0d value %0h, wanted %0h",
                                    result_cnt, out_word.geary_value, due.geary_value));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Directed part.
    put_sample(16'h0100, 1'b1);
    put_vector(2, 4);
    put_vector(3, 1);
    put_vector(2, 2);
    put_vector(2, 3);
    put_graph(1, 15, 1, 17'd65536, 1'b1);
    put_vector(2, 0);
    put_drain();
    // Random part: mostly well-formed vectors of small size.
    while (word_queue.size() < 950) begin
      case ($urandom_range(19))
        0: put_vector($urandom_range(2, 5), 1);
        1: put_vector($urandom_range(2, 4), 2);
        2: put_vector($urandom_range(2, 8), 3);
        3: put_vector($urandom_range(2, 8), 4);
        4: put_sample(pick_value(), 1'b1);
        5: put_graph($urandom_range(NODES - 1), $urandom_range(SLOTS - 1),
                     $urandom_range(NODES - 1), pick_weight(), 1'($urandom_range(1)));
        6: put_drain();
        default: put_vector($urandom_range(2, 12), 0);
      endcase
    end
    put_drain();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    do @(posedge clk);
    while (word_queue.size() > 0 || in_valid || geary_due.size() > 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gcknn_pkg.sv
src/gcknn_arith.sv
src/gcknn_dp.sv
src/gcknn_ctrl.sv
src/geary_c_knn_graph_unit.sv
test/tb_geary_c_knn_graph_unit.sv
